FILE: rtl/core/scd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scd_pkg
// Shared types and constants of the stream deframer: per-stream state entry,
// phase and result kind codes, register map.
// ----------------------------------------------------------------------------
package scd_pkg;

	localparam int STREAMS   = 16;
	localparam int IDX_W     = (STREAMS > 1) ? $clog2(STREAMS) : 1;
	localparam int STREAM_W  = 4;
	localparam int BYTE_W    = 8;
	localparam int LEN_W     = 16;
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;

	localparam logic [BYTE_W-1:0] ESC_BYTE = 8'hFF;

	// register index, taken from paddr above the byte offset
	localparam logic REG_MAX_LEN = 1'b0;
	localparam logic [LEN_W-1:0] MAX_LEN_RESET = 16'hFFFF;

	typedef enum logic [1:0] {
		PH_NORMAL = 2'd0,
		PH_ESCAPE = 2'd1,
		PH_QUOTE  = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_END  = 2'd1,
		KIND_LONG = 2'd2
	} kind_t;

	typedef struct packed {
		logic [1:0]       phase;
		logic [BYTE_W-1:0] quote_left;
		logic [LEN_W-1:0] msg_count;
		logic             dropping;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage
`default_nettype wire

FILE: rtl/core/scd_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scd_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module scd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/sigcomp_stream_deframer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sigcomp_stream_deframer
// Per-stream deframer for escaped byte streams with a length limit.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one raw byte and its stream number per
//   beat. Output channel (out_valid / out_stall): zero or one result per input
//   beat: a data byte, an end marker with the message length, or a too-long
//   flag. Results keep input order across all streams. A result passes the
//   work stage register and then the output register. Throughput: 1 beat per
//   cycle unless stalled. Per-stream state sits in a one-port-read,
//   one-port-write RAM; a read issued at accept is combined with the state
//   written back by the preceding beat through a forwarding register. Streams
//   at or above STREAMS are accepted and produce nothing. Reset: all streams
//   return to normal phase with empty messages at once (per-entry valid bits,
//   no clearing pass); the length limit returns to 65535. Configuration must be
//   written over the APB port while the block idles; the block does not check.
//   Stall: while out_stall holds a result, the work stage holds and in_stall
//   rises only if the work stage has an item; the output register keeps its
//   beat unchanged.
// ----------------------------------------------------------------------------
module sigcomp_stream_deframer (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// input channel
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [scd_pkg::STREAM_W-1:0]   stream_index,
	input  wire logic [scd_pkg::BYTE_W-1:0]     in_byte,
	// output channel
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic      [scd_pkg::STREAM_W-1:0]   out_stream,
	output logic      [1:0]                     out_kind,
	output logic      [scd_pkg::BYTE_W-1:0]     out_byte,
	output logic      [scd_pkg::LEN_W-1:0]      msg_length,
	// configuration
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [scd_pkg::PADDR_W-1:0]    paddr,
	input  wire logic [scd_pkg::PDATA_W-1:0]    pwdata,
	output logic      [scd_pkg::PDATA_W-1:0]    prdata,
	output logic                                pready
);

	logic [scd_pkg::LEN_W-1:0] max_len_q;

	logic                          valid_s1;
	logic [scd_pkg::STREAM_W-1:0]  stream_s1;
	logic [scd_pkg::BYTE_W-1:0]    byte_s1;
	logic                          in_range_s1;
	logic                          vld_s1;
	logic                          fwd_s1;
	scd_pkg::entry_t               fwd_entry_q;
	logic [scd_pkg::STREAMS-1:0]   valid_q;

	logic                          out_valid_q;
	logic [scd_pkg::STREAM_W-1:0]  out_stream_q;
	scd_pkg::kind_t                out_kind_q;
	logic [scd_pkg::BYTE_W-1:0]    out_byte_q;
	logic [scd_pkg::LEN_W-1:0]     out_len_q;

	logic                          accept;
	logic                          out_free;
	logic                          advance;
	logic                          wr_en;
	logic [scd_pkg::IDX_W-1:0]     rd_addr;
	logic [scd_pkg::IDX_W-1:0]     wr_addr;
	logic                          in_range;
	logic [scd_pkg::ENTRY_W-1:0]   ram_rdata;
	scd_pkg::entry_t               cur;
	scd_pkg::entry_t               nxt;
	logic                          res_valid;
	scd_pkg::kind_t                res_kind;
	logic [scd_pkg::BYTE_W-1:0]    res_byte;
	logic [scd_pkg::LEN_W-1:0]     res_len;
	logic                          emit;
	logic [scd_pkg::BYTE_W-1:0]    emit_byte;
	logic [scd_pkg::BYTE_W-1:0]    quote_dec;

	// ------------------------------------------------------------------------
	// configuration port
	// ------------------------------------------------------------------------
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= scd_pkg::MAX_LEN_RESET;
		end else if (psel && penable && pwrite && pready
				&& paddr[scd_pkg::PADDR_W-1] == scd_pkg::REG_MAX_LEN) begin
			max_len_q <= pwdata[scd_pkg::LEN_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[scd_pkg::PADDR_W-1] == scd_pkg::REG_MAX_LEN) begin
			prdata = {{(scd_pkg::PDATA_W-scd_pkg::LEN_W){1'b0}}, max_len_q};
		end
	end

	// ------------------------------------------------------------------------
	// handshake
	// ------------------------------------------------------------------------
	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign accept   = in_valid && !in_stall;

	assign rd_addr  = scd_pkg::IDX_W'(stream_index);
	assign wr_addr  = scd_pkg::IDX_W'(stream_s1);
	assign in_range = {{(32-scd_pkg::STREAM_W){1'b0}}, stream_index} < 32'(scd_pkg::STREAMS);
	assign wr_en    = advance && in_range_s1;

	// ------------------------------------------------------------------------
	// state memory
	// ------------------------------------------------------------------------
	scd_ram #(
		.WIDTH (scd_pkg::ENTRY_W),
		.DEPTH (scd_pkg::STREAMS)
	) u_state_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (nxt),
		.re    (accept),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	// entries never written read as the reset state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	// ------------------------------------------------------------------------
	// work stage
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			stream_s1   <= stream_index;
			byte_s1     <= in_byte;
			in_range_s1 <= in_range;
			vld_s1      <= in_range && valid_q[rd_addr];
			// the write-back at this edge is not yet visible in the RAM read
			fwd_s1      <= wr_en && (wr_addr == rd_addr);
			fwd_entry_q <= nxt;
		end
	end

	always_comb begin
		if (fwd_s1) begin
			cur = fwd_entry_q;
		end else if (vld_s1) begin
			cur = scd_pkg::entry_t'(ram_rdata);
		end else begin
			cur = '0;
		end
	end

	always_comb begin
		nxt       = cur;
		emit      = 1'b0;
		emit_byte = byte_s1;
		res_valid = 1'b0;
		res_kind  = scd_pkg::KIND_DATA;
		res_len   = '0;
		quote_dec = cur.quote_left - 8'd1;

		case (scd_pkg::phase_t'(cur.phase))
			scd_pkg::PH_QUOTE: begin
				nxt.quote_left = quote_dec;
				if (quote_dec == '0) begin
					nxt.phase = scd_pkg::PH_NORMAL;
				end
				emit = 1'b1;
			end
			scd_pkg::PH_ESCAPE: begin
				if (byte_s1 == scd_pkg::ESC_BYTE) begin
					// delimiter: close message
					nxt.phase     = scd_pkg::PH_NORMAL;
					nxt.msg_count = '0;
					nxt.dropping  = 1'b0;
					if (!cur.dropping && cur.msg_count != '0) begin
						res_valid = 1'b1;
						res_kind  = scd_pkg::KIND_END;
						res_len   = cur.msg_count;
					end
				end else begin
					nxt.quote_left = byte_s1;
					nxt.phase      = (byte_s1 != '0) ? scd_pkg::PH_QUOTE
						: scd_pkg::PH_NORMAL;
					emit_byte      = scd_pkg::ESC_BYTE;
					emit           = 1'b1;
				end
			end
			default: begin
				if (byte_s1 == scd_pkg::ESC_BYTE) begin
					nxt.phase = scd_pkg::PH_ESCAPE;
				end else begin
					nxt.phase = scd_pkg::PH_NORMAL;
					emit      = 1'b1;
				end
			end
		endcase

		// count a data byte, or flag the message once it hits the limit
		if (emit && !cur.dropping) begin
			res_valid = 1'b1;
			if (cur.msg_count >= max_len_q) begin
				nxt.dropping = 1'b1;
				res_kind     = scd_pkg::KIND_LONG;
			end else begin
				nxt.msg_count = cur.msg_count + 16'd1;
				res_kind      = scd_pkg::KIND_DATA;
			end
		end

		res_byte = (res_valid && res_kind == scd_pkg::KIND_DATA) ? emit_byte : '0;
	end

	// ------------------------------------------------------------------------
	// output register
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && in_range_s1 && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_range_s1 && res_valid) begin
			out_stream_q <= stream_s1;
			out_kind_q   <= res_kind;
			out_byte_q   <= res_byte;
			out_len_q    <= res_len;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_stream = out_stream_q;
	assign out_kind   = out_kind_q;
	assign out_byte   = out_byte_q;
	assign msg_length = out_len_q;

endmodule
`default_nettype wire

FILE: rtl/core/scd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scd_checker
// Port-level checks of the stream deframer, bound to the top level.
// ----------------------------------------------------------------------------
module scd_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           out_valid,
	input wire logic                           out_stall,
	input wire logic [scd_pkg::STREAM_W-1:0]   out_stream,
	input wire logic [1:0]                     out_kind,
	input wire logic [scd_pkg::BYTE_W-1:0]     out_byte,
	input wire logic [scd_pkg::LEN_W-1:0]      msg_length
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_stream)
			&& $stable(out_kind) && $stable(out_byte) && $stable(msg_length))
		else $error("stalled result changed");

	// an end marker never reports an empty message
	a_end_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == scd_pkg::KIND_END |-> msg_length != '0)
		else $error("end marker with zero length");

	// only data carries a byte, only an end marker carries a length
	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind != scd_pkg::KIND_DATA |-> out_byte == '0)
		else $error("byte set on non-data result");

	a_len_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind != scd_pkg::KIND_END |-> msg_length == '0)
		else $error("length set on non-end result");

endmodule

bind sigcomp_stream_deframer scd_checker u_scd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.out_stream (out_stream),
	.out_kind   (out_kind),
	.out_byte   (out_byte),
	.msg_length (msg_length)
);
`default_nettype wire

FILE: sim/tb_sigcomp_stream_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sigcomp_stream_deframer
// Self-checking bench for the stream deframer: a directed table of escape,
// quote, delimiter and length-limit cases, then interleaved random messages
// under several length limits, with bursty input and a stalling receiver.
// Every output beat is checked against table rows or an in-bench model.
// ----------------------------------------------------------------------------
module tb_sigcomp_stream_deframer;

	localparam int IDLE_LIMIT  = 2000;
	localparam int DRAIN_WAIT  = 4;
	localparam int TAIL_WAIT   = 10;
	localparam int PHASE_ITEMS = 115;
	localparam int DIR_N       = 25;

	localparam logic [1:0] CHK_PRED  = 2'd0;
	localparam logic [1:0] CHK_NONE  = 2'd1;
	localparam logic [1:0] CHK_TYPED = 2'd2;

	localparam logic [scd_pkg::PADDR_W-1:0] ADDR_MAX_LEN = {scd_pkg::REG_MAX_LEN, 2'b00};

	typedef struct packed {
		logic [scd_pkg::STREAM_W-1:0] strm;
		scd_pkg::kind_t               kind;
		logic [scd_pkg::BYTE_W-1:0]   dbyte;
		logic [scd_pkg::LEN_W-1:0]    len;
	} deframe_item_t;

	typedef struct packed {
		logic [scd_pkg::LEN_W-1:0]    limit;
		logic [scd_pkg::STREAM_W-1:0] strm;
		logic [scd_pkg::BYTE_W-1:0]   b;
		logic [1:0]                   chk;
		scd_pkg::kind_t               kind;
		logic [scd_pkg::BYTE_W-1:0]   ob;
		logic [scd_pkg::LEN_W-1:0]    len;
	} dir_row_t;

	logic                         clk          = 1'b0;
	logic                         arst_n       = 1'b0;
	logic                         in_valid     = 1'b0;
	logic                         in_stall;
	logic [scd_pkg::STREAM_W-1:0] stream_index = '0;
	logic [scd_pkg::BYTE_W-1:0]   in_byte      = '0;
	logic                         out_valid;
	logic                         out_stall    = 1'b0;
	logic [scd_pkg::STREAM_W-1:0] out_stream;
	logic [1:0]                   out_kind;
	logic [scd_pkg::BYTE_W-1:0]   out_byte;
	logic [scd_pkg::LEN_W-1:0]    msg_length;
	logic                         psel         = 1'b0;
	logic                         penable      = 1'b0;
	logic                         pwrite       = 1'b0;
	logic [scd_pkg::PADDR_W-1:0]  paddr        = '0;
	logic [scd_pkg::PDATA_W-1:0]  pwdata       = '0;
	logic [scd_pkg::PDATA_W-1:0]  prdata;
	logic                         pready;

	// deframer model state
	scd_pkg::phase_t            st_phase [scd_pkg::STREAMS];
	logic [scd_pkg::BYTE_W-1:0] st_quote [scd_pkg::STREAMS];
	logic [scd_pkg::LEN_W-1:0]  st_count [scd_pkg::STREAMS];
	bit                         st_drop  [scd_pkg::STREAMS];
	logic [scd_pkg::LEN_W-1:0]  max_len = scd_pkg::MAX_LEN_RESET;

	deframe_item_t awaited_items [$];
	int            errors     = 0;
	int            idle_count = 0;
	int            burst_left = 0;

	// random message generator, one per stream
	int gen_left  [scd_pkg::STREAMS];
	int gen_quote [scd_pkg::STREAMS];
	bit gen_esc   [scd_pkg::STREAMS];
	bit gen_delim [scd_pkg::STREAMS];

	dir_row_t dir_rows [DIR_N] = '{
		'{16'hFFFF, 4'd0,  8'h00, CHK_TYPED, scd_pkg::KIND_DATA, 8'h00, 16'd0},
		'{16'hFFFF, 4'd0,  8'h7F, CHK_PRED,  scd_pkg::KIND_DATA, 8'h00, 16'd0},
		'{16'hFFFF, 4'd0,  8'hFF, CHK_NONE,  scd_pkg::KIND_DATA, 8'h00, 16'd0},
		'{16'hFFFF, 4'd0,  8'hFF, CHK_TYPED, scd_pkg::KIND_END,  8'h00, 16'd2},
		// empty message
		'{16'hFFFF, 4'd1,  8'hFF, CHK_NONE,  scd_pkg::KIND_DATA, 8'h00, 16'd0},
		'{16'hFFFF, 4'd1,  8'hFF, CHK_NONE,  scd_pkg::KIND_DATA, 8'h00, 16'd0},
		// zero quote
		'{16'hFFFF, 4'd2,  8'hFF, CHK_NONE,  scd_pkg::KIND_DATA, 8'h00, 16'd0},
		'{16'hFFFF, 4'd2,  8'h00, CHK_TYPED, scd_pkg::KIND_DATA, 8'hFF, 16'd0},
		'{16'hFFFF, 4'd2,  8'hFF, CHK_NONE,  scd_pkg::KIND_DATA, 8'h00, 16'd0},
		'{16'hFFFF, 4'd2,  8'hFF, CHK_TYPED, scd_pkg::KIND_END,  8'h00, 16'd1},
		// quote of two, with a literal 0xFF inside
		'{16'hFFFF, 4'd3,  8'hFF, CHK_NONE,  scd_pkg::KIND_DATA, 8'h00, 16'd0},
		'{16'hFFFF, 4'd3,  8'h02, CHK_TYPED, scd_pkg::KIND_DATA, 8'hFF, 16'd0},
		'{16'hFFFF, 4'd3,  8'hFF, CHK_PRED,  scd_pkg::KIND_DATA, 8'h00, 16'd0},
		'{16'hFFFF, 4'd3,  8'h55, CHK_PRED,  scd_pkg::KIND_DATA, 8'h00, 16'd0},
		'{16'hFFFF, 4'd3,  8'hFF, CHK_NONE,  scd_pkg::KIND_DATA, 8'h00, 16'd0},
		'{16'hFFFF, 4'd3,  8'hFF, CHK_TYPED, scd_pkg::KIND_END,  8'h00, 16'd3},
		// reserved quote count, left running
		'{16'hFFFF, 4'd4,  8'hFF, CHK_NONE,  scd_pkg::KIND_DATA, 8'h00, 16'd0},
		'{16'hFFFF, 4'd4,  8'hFE, CHK_TYPED, scd_pkg::KIND_DATA, 8'hFF, 16'd0},
		'{16'hFFFF, 4'd15, 8'h80, CHK_PRED,  scd_pkg::KIND_DATA, 8'h00, 16'd0},
		// length limit of one: flag, drop, delimiter clears
		'{16'd1,    4'd5,  8'h11, CHK_TYPED, scd_pkg::KIND_DATA, 8'h11, 16'd0},
		'{16'd1,    4'd5,  8'h22, CHK_TYPED, scd_pkg::KIND_LONG, 8'h00, 16'd0},
		'{16'd1,    4'd5,  8'h33, CHK_NONE,  scd_pkg::KIND_DATA, 8'h00, 16'd0},
		'{16'd1,    4'd5,  8'hFF, CHK_NONE,  scd_pkg::KIND_DATA, 8'h00, 16'd0},
		'{16'd1,    4'd5,  8'hFF, CHK_NONE,  scd_pkg::KIND_DATA, 8'h00, 16'd0},
		'{16'd1,    4'd5,  8'h44, CHK_TYPED, scd_pkg::KIND_DATA, 8'h44, 16'd0}
	};

	sigcomp_stream_deframer u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.stream_index (stream_index),
		.in_byte      (in_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_stream   (out_stream),
		.out_kind     (out_kind),
		.out_byte     (out_byte),
		.msg_length   (msg_length),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always #4 clk = ~clk;

	// Step the deframer model by one byte; returns 1 when a result is due.
	function automatic bit deframe_predict(input logic [scd_pkg::STREAM_W-1:0] s,
			input logic [scd_pkg::BYTE_W-1:0] b, output deframe_item_t r);
		logic [scd_pkg::BYTE_W-1:0] db;
		logic [scd_pkg::LEN_W-1:0]  n;
		bit                         was_drop;
		r = '{s, scd_pkg::KIND_DATA, 8'd0, 16'd0};
		db = b;
		if (int'(s) >= scd_pkg::STREAMS)
			return 1'b0;
		case (st_phase[s])
			scd_pkg::PH_QUOTE: begin
				st_quote[s] = st_quote[s] - 8'd1;
				if (st_quote[s] == 8'd0)
					st_phase[s] = scd_pkg::PH_NORMAL;
			end
			scd_pkg::PH_ESCAPE: begin
				if (b == scd_pkg::ESC_BYTE) begin
					st_phase[s] = scd_pkg::PH_NORMAL;
					n = st_count[s];
					was_drop = st_drop[s];
					st_count[s] = '0;
					st_drop[s] = 1'b0;
					if (was_drop || n == '0)
						return 1'b0;
					r.kind = scd_pkg::KIND_END;
					r.len = n;
					return 1'b1;
				end
				st_quote[s] = b;
				st_phase[s] = (b != 8'd0) ? scd_pkg::PH_QUOTE : scd_pkg::PH_NORMAL;
				db = scd_pkg::ESC_BYTE;
			end
			default: begin
				if (b == scd_pkg::ESC_BYTE) begin
					st_phase[s] = scd_pkg::PH_ESCAPE;
					return 1'b0;
				end
				st_phase[s] = scd_pkg::PH_NORMAL;
			end
		endcase
		// count one data byte
		if (st_drop[s])
			return 1'b0;
		if (st_count[s] >= max_len) begin
			st_drop[s] = 1'b1;
			r.kind = scd_pkg::KIND_LONG;
			return 1'b1;
		end
		st_count[s] = st_count[s] + 16'd1;
		r.dbyte = db;
		return 1'b1;
	endfunction

	// Next byte of a well-formed random message on stream s.
	function automatic logic [scd_pkg::BYTE_W-1:0] next_msg_byte(input int s);
		int pick;
		if (gen_delim[s]) begin
			gen_delim[s] = 1'b0;
			gen_left[s] = $urandom_range(0, 10);
			return scd_pkg::ESC_BYTE;
		end
		if (gen_esc[s]) begin
			gen_esc[s] = 1'b0;
			pick = $urandom_range(0, 39);
			if (pick == 0)
				gen_quote[s] = $urandom_range(8'h80, 8'hFE);
			else if (pick == 1)
				gen_quote[s] = $urandom_range(5, 8'h7F);
			else
				gen_quote[s] = $urandom_range(0, 4);
			return gen_quote[s][7:0];
		end
		if (gen_quote[s] > 0) begin
			gen_quote[s]--;
			return ($urandom_range(0, 3) == 0) ? scd_pkg::ESC_BYTE
				: 8'($urandom_range(0, 255));
		end
		if (gen_left[s] == 0) begin
			gen_delim[s] = 1'b1;
			return scd_pkg::ESC_BYTE;
		end
		gen_left[s]--;
		if ($urandom_range(0, 4) == 0) begin
			gen_esc[s] = 1'b1;
			return scd_pkg::ESC_BYTE;
		end
		return 8'($urandom_range(0, 8'hFE));
	endfunction

	task automatic send_beat(input logic [scd_pkg::STREAM_W-1:0] s,
			input logic [scd_pkg::BYTE_W-1:0] b);
		bit taken;
		in_valid <= 1'b1;
		stream_index <= s;
		in_byte <= b;
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
	endtask

	// Sender bursts: open a gap between bursts now and then.
	task automatic pace();
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (awaited_items.size() != 0)
			@(posedge clk);
		// let result-less beats leave the pipeline
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic apb_access(input bit wr, input logic [scd_pkg::PADDR_W-1:0] a,
			input logic [scd_pkg::PDATA_W-1:0] d, output logic [scd_pkg::PDATA_W-1:0] rd);
		bit done;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= a;
		pwdata <= d;
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(negedge clk);
			done = pready;
			rd = prdata;
			@(posedge clk);
		end while (!done);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_max_len(input logic [scd_pkg::LEN_W-1:0] v);
		logic [scd_pkg::PDATA_W-1:0] rd;
		wait_drained();
		apb_access(1'b1, ADDR_MAX_LEN, {{(scd_pkg::PDATA_W-scd_pkg::LEN_W){1'b0}}, v}, rd);
		max_len = v;
		apb_access(1'b0, ADDR_MAX_LEN, '0, rd);
		if (rd[scd_pkg::LEN_W-1:0] !== v) begin
			errors++;
			$display("%0t max_message_len readback: expected %0d actual %0d",
				$time, v, rd[scd_pkg::LEN_W-1:0]);
		end
	endtask

	// Receiver: stall pattern switches between none, random and heavy.
	int stall_mode = 0;
	int mode_left  = 0;
	always @(posedge clk) begin
		if (mode_left == 0) begin
			stall_mode <= $urandom_range(0, 2);
			mode_left <= $urandom_range(50, 300);
		end else begin
			mode_left <= mode_left - 1;
		end
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 99) < 35);
			default: out_stall <= ($urandom_range(0, 7) != 0);
		endcase
	end

	// Check each output beat against the oldest awaited result.
	always @(negedge clk) begin
		deframe_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (awaited_items.size() == 0) begin
				errors++;
				$display({"%0t unexpected beat: expected none",
					" actual s=%0d k=%0d b=%02h len=%0d"},
					$time, out_stream, out_kind, out_byte, msg_length);
			end else begin
				want = awaited_items.pop_front();
				if (out_stream !== want.strm || out_kind !== want.kind
						|| out_byte !== want.dbyte || msg_length !== want.len) begin
					errors++;
					$display({"%0t mismatch: expected s=%0d k=%0d b=%02h len=%0d",
						" actual s=%0d k=%0d b=%02h len=%0d"},
						$time, want.strm, want.kind, want.dbyte, want.len,
						out_stream, out_kind, out_byte, msg_length);
				end
			end
		end
	end

	// Watchdog: end the run when no beat moves for too long.
	always @(negedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_count <= 0;
		end else if (idle_count >= IDLE_LIMIT) begin
			$display("sigcomp_stream_deframer regression: fail");
			$finish;
		end else begin
			idle_count <= idle_count + 1;
		end
	end

	initial begin
		deframe_item_t                item;
		bit                           hit;
		logic [scd_pkg::STREAM_W-1:0] s;
		logic [scd_pkg::BYTE_W-1:0]   b;
		logic [scd_pkg::LEN_W-1:0]    limits [6];
		for (int i = 0; i < scd_pkg::STREAMS; i++) begin
			st_phase[i] = scd_pkg::PH_NORMAL;
			st_quote[i] = '0;
			st_count[i] = '0;
			st_drop[i] = 1'b0;
			gen_left[i] = 0;
			gen_quote[i] = 0;
			gen_esc[i] = 1'b0;
			gen_delim[i] = 1'b0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int i = 0; i < DIR_N; i++) begin
			if (dir_rows[i].limit != max_len)
				set_max_len(dir_rows[i].limit);
			pace();
			send_beat(dir_rows[i].strm, dir_rows[i].b);
			hit = deframe_predict(dir_rows[i].strm, dir_rows[i].b, item);
			case (dir_rows[i].chk)
				CHK_PRED: if (hit) awaited_items.push_back(item);
				CHK_TYPED: awaited_items.push_back(deframe_item_t'{dir_rows[i].strm,
					dir_rows[i].kind, dir_rows[i].ob, dir_rows[i].len});
				default: ;
			endcase
		end

		// random messages under several limits
		limits = '{16'd1, 16'($urandom_range(2, 8)), scd_pkg::MAX_LEN_RESET,
			16'($urandom_range(3, 30)), 16'($urandom_range(1, 65535)),
			scd_pkg::MAX_LEN_RESET};
		for (int p = 0; p < 6; p++) begin
			set_max_len(limits[p]);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(0, 11) == 0) begin
					// noise: any byte on any stream
					s = scd_pkg::STREAM_W'($urandom_range(0, scd_pkg::STREAMS - 1));
					b = 8'($urandom_range(0, 255));
				end else begin
					s = scd_pkg::STREAM_W'(($urandom_range(0, 9) < 7) ? $urandom_range(0, 3)
						: $urandom_range(0, scd_pkg::STREAMS - 1));
					b = next_msg_byte(int'(s));
				end
				if ($urandom_range(0, 149) == 0)
					wait_drained();
				pace();
				send_beat(s, b);
				if (deframe_predict(s, b, item))
					awaited_items.push_back(item);
			end
		end

		in_valid <= 1'b0;
		while (awaited_items.size() != 0)
			@(posedge clk);
		repeat (TAIL_WAIT) @(posedge clk);
		if (errors == 0)
			$display("sigcomp_stream_deframer regression: pass");
		else
			$display("sigcomp_stream_deframer regression: fail");
		$finish;
	end

endmodule

FILE: files.f
rtl/core/scd_pkg.sv
rtl/core/scd_ram.sv
rtl/core/sigcomp_stream_deframer.sv
rtl/core/scd_checker.sv
sim/tb_sigcomp_stream_deframer.sv
